// File: hw/rtl/pvd_pkg.sv
// Shared types and constants for the postings varint delta decoder.
// No dependencies; every other file imports this package.
package pvd_pkg;

	localparam int QueueDepthDefault = 4;

	localparam logic [1:0] KIND_COUNT  = 2'd0;
	localparam logic [1:0] KIND_ROWID  = 2'd1;
	localparam logic [1:0] KIND_END_OK = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_VERSION  = 3'd1;
	localparam logic [2:0] ERR_TRUNC    = 3'd2;
	localparam logic [2:0] ERR_VARINT   = 3'd3;
	localparam logic [2:0] ERR_OVER_MAX = 3'd4;
	localparam logic [2:0] ERR_ZERO     = 3'd5;
	localparam logic [2:0] ERR_SUM      = 3'd6;
	localparam logic [2:0] ERR_TRAILING = 3'd7;

	localparam logic [7:0] VERSION_RESET = 8'd1;
	localparam logic [5:0] SHIFT_LAST    = 6'd63;
	localparam logic [5:0] SHIFT_STEP    = 6'd7;

	typedef enum logic [1:0] {
		PH_VERSION = 2'd0,
		PH_COUNT   = 2'd1,
		PH_DELTA   = 2'd2,
		PH_END     = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] blob_byte;
		logic       blob_end;
	} pvd_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [62:0] value;
		logic [2:0]  error_code;
		logic        run_last;
	} pvd_result_t;

	typedef struct packed {
		logic        two;
		pvd_result_t r0;
		pvd_result_t r1;
	} pvd_group_t;

endpackage

// File: hw/rtl/pvd_front.sv
// Front end: input register, blob parser and decoder state.
// Turns each byte into a group of up to two result words. Uses pvd_pkg.
module pvd_front
	import pvd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  pvd_item_t  item,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       q_full,
	output logic       q_push,
	output pvd_group_t q_wdata
);

	logic        v_s1;
	pvd_item_t   item_s1;
	logic        adv;
	logic [7:0]  ver_q;

	phase_t      ph_q, ph_d;
	logic [63:0] acc_q, acc_d;
	logic [5:0]  sh_q, sh_d;
	logic [62:0] left_q, left_d;
	logic [62:0] row_q, row_d;
	logic        first_q, first_d;
	logic        failed_q, failed_d;

	logic [7:0]  b;
	logic        e;
	logic [63:0] acc_new;
	logic [63:0] sum;
	logic [62:0] left_dec;
	logic        err;
	logic [2:0]  code;
	logic [1:0]  nres;
	pvd_result_t r0, r1;

	assign adv  = v_s1 && !q_full;
	assign full = v_s1 && q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (push && !full) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_q <= VERSION_RESET;
		end else if (cfg_we) begin
			ver_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_VERSION;
			acc_q    <= '0;
			sh_q     <= '0;
			left_q   <= '0;
			row_q    <= '0;
			first_q  <= 1'b1;
			failed_q <= 1'b0;
		end else if (adv) begin
			ph_q     <= ph_d;
			acc_q    <= acc_d;
			sh_q     <= sh_d;
			left_q   <= left_d;
			row_q    <= row_d;
			first_q  <= first_d;
			failed_q <= failed_d;
		end
	end

	assign b        = item_s1.blob_byte;
	assign e        = item_s1.blob_end;
	assign acc_new  = acc_q | ({57'd0, b[6:0]} << sh_q);
	assign sum      = {1'b0, acc_new[62:0]} + {1'b0, row_q};
	assign left_dec = left_q - 63'd1;

	always_comb begin
		ph_d     = ph_q;
		acc_d    = acc_q;
		sh_d     = sh_q;
		left_d   = left_q;
		row_d    = row_q;
		first_d  = first_q;
		failed_d = failed_q;
		r0       = '0;
		r1       = '0;
		nres     = 2'd0;
		err      = 1'b0;
		code     = ERR_NONE;
		if (!failed_q) begin
			unique case (ph_q)
				PH_VERSION: begin
					if (b != ver_q) begin
						err  = 1'b1;
						code = ERR_VERSION;
					end else if (e) begin
						err  = 1'b1;
						code = ERR_TRUNC;
					end else begin
						ph_d  = PH_COUNT;
						acc_d = '0;
						sh_d  = '0;
					end
				end
				PH_END: begin
					err  = 1'b1;
					code = ERR_TRAILING;
				end
				PH_COUNT, PH_DELTA: begin
					if (sh_q == SHIFT_LAST && b[7:1] != 7'd0) begin
						err  = 1'b1;
						code = ERR_VARINT;
					end else if (b[7]) begin
						acc_d = acc_new;
						sh_d  = sh_q + SHIFT_STEP;
						if (e) begin
							err  = 1'b1;
							code = ERR_TRUNC;
						end
					end else begin
						acc_d = '0;
						sh_d  = '0;
						if (acc_new[63]) begin
							err  = 1'b1;
							code = ERR_OVER_MAX;
						end else if (ph_q == PH_COUNT) begin
							r0   = '{kind: KIND_COUNT, value: acc_new[62:0],
								error_code: ERR_NONE, run_last: 1'b0};
							nres = 2'd1;
							if (acc_new == 64'd0) begin
								ph_d = PH_END;
								if (e) begin
									r1   = '{kind: KIND_END_OK, value: '0,
										error_code: ERR_NONE, run_last: 1'b0};
									nres = 2'd2;
								end
							end else if (e) begin
								err  = 1'b1;
								code = ERR_TRUNC;
							end else begin
								ph_d    = PH_DELTA;
								left_d  = acc_new[62:0];
								row_d   = '0;
								first_d = 1'b1;
							end
						end else begin
							if (!first_q && acc_new == 64'd0) begin
								err  = 1'b1;
								code = ERR_ZERO;
							end else if (sum[63]) begin
								err  = 1'b1;
								code = ERR_SUM;
							end else begin
								row_d   = sum[62:0];
								first_d = 1'b0;
								left_d  = left_dec;
								r0      = '{kind: KIND_ROWID, value: sum[62:0],
									error_code: ERR_NONE, run_last: 1'b0};
								nres    = 2'd1;
								if (left_dec == 63'd0) begin
									ph_d = PH_END;
									if (e) begin
										r1   = '{kind: KIND_END_OK, value: '0,
											error_code: ERR_NONE, run_last: 1'b0};
										nres = 2'd2;
									end
								end else if (e) begin
									err  = 1'b1;
									code = ERR_TRUNC;
								end
							end
						end
					end
				end
				default: begin
					ph_d = PH_VERSION;
				end
			endcase
		end
		if (err) begin
			failed_d = 1'b1;
			if (nres == 2'd0) begin
				r0   = '{kind: KIND_ERROR, value: '0, error_code: code, run_last: 1'b0};
				nres = 2'd1;
			end else begin
				r1   = '{kind: KIND_ERROR, value: '0, error_code: code, run_last: 1'b0};
				nres = 2'd2;
			end
		end
		// end of blob: back to a clean start
		if (e) begin
			ph_d     = PH_VERSION;
			acc_d    = '0;
			sh_d     = '0;
			left_d   = '0;
			row_d    = '0;
			first_d  = 1'b1;
			failed_d = 1'b0;
		end
		if (nres == 2'd2) begin
			r1.run_last = 1'b1;
		end else begin
			r0.run_last = 1'b1;
		end
	end

	assign q_push  = adv && nres != 2'd0;
	assign q_wdata = '{two: nres == 2'd2, r0: r0, r1: r1};

endmodule

// File: hw/rtl/pvd_queue.sv
// Short queue of result groups between the front end and the output stage.
// Register array with wrapping pointers. Uses pvd_pkg.
module pvd_queue
	import pvd_pkg::*;
#(
	parameter int DEPTH = QueueDepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  pvd_group_t wdata,
	output logic       q_full,
	input  logic       rd,
	output pvd_group_t rdata,
	output logic       q_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pvd_group_t    mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign q_full  = cnt_q == CW'(DEPTH);
	assign q_empty = cnt_q == '0;
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/pvd_back.sv
// Output stage: splits each result group into single words and holds
// the word on offer until popped. Uses pvd_pkg.
module pvd_back
	import pvd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  pvd_group_t  q_rdata,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output pvd_result_t result
);

	logic        out_v_q, pend_v_q;
	pvd_result_t out_q, pend_q;
	logic        take, free;

	assign take   = out_v_q && pop;
	assign free   = !out_v_q || take;
	assign q_pop  = free && !pend_v_q && !q_empty;
	assign empty  = !out_v_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (take && pend_v_q) begin
			pend_v_q <= 1'b0;
		end else if (q_pop) begin
			out_v_q  <= 1'b1;
			pend_v_q <= q_rdata.two;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && pend_v_q) begin
			out_q <= pend_q;
		end else if (q_pop) begin
			out_q  <= q_rdata.r0;
			pend_q <= q_rdata.r1;
		end
	end

endmodule

// File: hw/rtl/postings_varint_delta_decoder.sv
// Top level of the postings varint delta decoder.
// Instantiates pvd_front, pvd_queue and pvd_back; uses pvd_pkg.
//
// Takes one blob byte per cycle while full is low: a byte is registered,
// parsed (version check, base-128 varint assembly, 63-bit running sum) and
// its one or two result words go into a queue of QUEUE_DEPTH groups. The
// first result of a byte passes the queue and the output register before
// it is on offer. Results leave at one word per cycle while pop is held;
// the queue absorbs the bursts of bytes that end a blob with two words,
// and full rises only when it is full and a parsed byte is waiting.
module postings_varint_delta_decoder
	import pvd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  pvd_item_t   item,
	output logic        empty,
	input  logic        pop,
	output pvd_result_t result,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	logic       q_full, q_push, q_empty, q_pop;
	pvd_group_t q_wdata, q_rdata;

	pvd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	pvd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.q_full (q_full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.q_empty(q_empty)
	);

	pvd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_rdata(q_rdata),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind != KIND_ERROR) |-> result.error_code == ERR_NONE)
		else $error("error code on a non-error word");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.kind == KIND_END_OK || result.kind == KIND_ERROR))
			|-> result.value == '0)
		else $error("value on an end or error word");

	a_second_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !result.run_last) |=> !empty)
		else $error("second word of a byte not ready");

	a_no_push_lost: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("result group pushed into a full queue");

endmodule
